[rtl/core/rau_pkg.sv]
// shared types and constants for the rational arithmetic unit
package rau_pkg;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_NORM = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_OVF = 2'd1,
    ST_DIV0 = 2'd2,
    ST_ZDEN = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_CHECK,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic div_save_num;
    logic check;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic early_err;
    logic gcd_done;
    logic div_done;
  } stat_t;

endpackage

[rtl/core/rational_arith_unit.sv]
// top level of the rational arithmetic unit
// sequence: on an early error (zero denominator or divide by zero) the strobe follows
// the first multiply state; else three multiplies and a sum, then a binary gcd,
// then two divisions (numerator, then denominator) and a check
// throughput: one item at a time, busy high from transfer to strobe, next transfer after it
// reset: synchronous active-low rst_n returns the controller to idle; no receiver stall
module rational_arith_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_a_num,
  input  logic [31:0] in_a_den,
  input  logic [31:0] in_b_num,
  input  logic [30:0] in_b_den,
  output logic        out_valid,
  output logic [31:0] out_res_num,
  output logic [30:0] out_res_den,
  output logic [1:0]  out_status
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  // sequencer
  rau_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (out_valid)
  );

  // arithmetic, gcd and division
  rau_dp #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk        (clk),
    .in_command (in_command),
    .in_a_num   (in_a_num),
    .in_a_den   (in_a_den),
    .in_b_num   (in_b_num),
    .in_b_den   (in_b_den),
    .ctrl       (ctrl),
    .stat       (stat),
    .res_num    (out_res_num),
    .res_den    (out_res_den),
    .res_status (out_status)
  );

  // a transfer always starts work
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not start work");

  // the strobe ends the item
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result strobe");

  // errors carry zero fields
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != rau_pkg::ST_OK) |-> (out_res_num == '0 && out_res_den == '0))
    else $error("error result with non-zero fields");

endmodule

[rtl/core/rau_ctrl.sv]
// controller state machine for the rational arithmetic unit
module rau_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  rau_pkg::stat_t  stat,
  output rau_pkg::ctrl_t  ctrl,
  output logic            busy,
  output logic            done
);

  rau_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rau_pkg::S_IDLE:  if (start) state_nxt = rau_pkg::S_MUL1;
      rau_pkg::S_MUL1:  state_nxt = stat.early_err ? rau_pkg::S_DONE : rau_pkg::S_MUL2;
      rau_pkg::S_MUL2:  state_nxt = rau_pkg::S_MUL3;
      rau_pkg::S_MUL3:  state_nxt = rau_pkg::S_SUM;
      rau_pkg::S_SUM:   state_nxt = rau_pkg::S_GCD;
      rau_pkg::S_GCD:   if (stat.gcd_done) state_nxt = rau_pkg::S_DIVN;
      rau_pkg::S_DIVN:  if (stat.div_done) state_nxt = rau_pkg::S_DIVD;
      rau_pkg::S_DIVD:  if (stat.div_done) state_nxt = rau_pkg::S_CHECK;
      rau_pkg::S_CHECK: state_nxt = rau_pkg::S_DONE;
      rau_pkg::S_DONE:  state_nxt = rau_pkg::S_IDLE;
      default:          state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = (state_r != rau_pkg::S_IDLE);
    done = (state_r == rau_pkg::S_DONE);
    case (state_r)
      rau_pkg::S_IDLE:  ctrl.load = start;
      rau_pkg::S_MUL1:  ctrl.mul1 = 1'b1;
      rau_pkg::S_MUL2:  ctrl.mul2 = 1'b1;
      rau_pkg::S_MUL3:  ctrl.mul3 = 1'b1;
      rau_pkg::S_SUM:   ctrl.sum = 1'b1;
      rau_pkg::S_GCD: begin
        ctrl.gcd_step = 1'b1;
        ctrl.div_init = stat.gcd_done;
      end
      rau_pkg::S_DIVN: begin
        ctrl.div_step = 1'b1;
        ctrl.div_save_num = stat.div_done;
      end
      rau_pkg::S_DIVD:  ctrl.div_step = 1'b1;
      rau_pkg::S_CHECK: ctrl.check = 1'b1;
      default: ;
    endcase
  end

endmodule

[rtl/core/rau_dp.sv]
// datapath: cross products, binary gcd and restoring division
module rau_dp #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic [2:0]           in_command,
  input  logic [31:0]          in_a_num,
  input  logic [31:0]          in_a_den,
  input  logic [31:0]          in_b_num,
  input  logic [30:0]          in_b_den,
  input  rau_pkg::ctrl_t       ctrl,
  output rau_pkg::stat_t       stat,
  output logic [31:0]          res_num,
  output logic [30:0]          res_den,
  output logic [1:0]           res_status
);

  localparam int W2 = 2 * WORD_BITS;
  localparam int CW = $clog2(W2 + 1);

  logic [2:0]            cmd_r;
  logic signed [W2-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [W2-1:0]  p1_r, p2_r, p3_r;
  logic [W2-1:0]         nm_r, dm_r, gu_r, gv_r, q_r, rem_r, qn_r;
  logic [CW-1:0]         sh_r, cnt_r;
  logic                  neg_r;
  logic [1:0]            st_r;
  logic [31:0]           onum_r;
  logic [30:0]           oden_r;

  logic signed [WORD_BITS-1:0] mx, my;
  logic signed [W2-1:0] mprod;
  logic signed [W2-1:0] num_v, den_v;
  logic [W2-1:0]        nmag, dmag, gdiff, rtry;
  logic                 is_norm, zden, div0;

  assign is_norm = cmd_r[2];
  assign zden = (ad_r == '0) || (!is_norm && bd_r == '0);
  assign div0 = (cmd_r == rau_pkg::CMD_DIV) && (bn_r == '0);

  // one shared word by word multiplier, one product per cycle
  always_comb begin
    mx = ad_r[WORD_BITS-1:0];
    my = bd_r[WORD_BITS-1:0];
    if (ctrl.mul1) begin
      mx = an_r[WORD_BITS-1:0];
      my = (cmd_r == rau_pkg::CMD_MUL) ? bn_r[WORD_BITS-1:0] : bd_r[WORD_BITS-1:0];
    end else if (ctrl.mul2) begin
      mx = ad_r[WORD_BITS-1:0];
      my = bn_r[WORD_BITS-1:0];
    end
  end
  assign mprod = W2'(mx) * W2'(my);

  always_comb begin
    num_v = p1_r;
    den_v = p3_r;
    case (cmd_r)
      rau_pkg::CMD_ADD: num_v = p1_r + p2_r;
      rau_pkg::CMD_SUB: num_v = p1_r - p2_r;
      rau_pkg::CMD_MUL: num_v = p1_r;
      rau_pkg::CMD_DIV: begin
        num_v = p1_r;
        den_v = p2_r;
      end
      default: begin
        num_v = an_r;
        den_v = ad_r;
      end
    endcase
  end
  assign nmag = num_v[W2-1] ? W2'(-num_v) : W2'(num_v);
  assign dmag = den_v[W2-1] ? W2'(-den_v) : W2'(den_v);

  assign gdiff = (gu_r > gv_r) ? gu_r - gv_r : gv_r - gu_r;
  assign rtry = {rem_r[W2-2:0], q_r[W2-1]};

  assign stat.early_err = zden || div0;
  assign stat.gcd_done = (gv_r == '0);
  assign stat.div_done = (cnt_r == CW'(W2));

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r <= in_command;
      an_r <= W2'(signed'(in_a_num[WORD_BITS-1:0]));
      ad_r <= W2'(signed'(in_a_den[WORD_BITS-1:0]));
      bn_r <= W2'(signed'(in_b_num[WORD_BITS-1:0]));
      bd_r <= W2'({1'b0, in_b_den[WORD_BITS-2:0]});
    end
    if (ctrl.mul1) begin
      p1_r <= mprod;
      st_r <= zden ? rau_pkg::ST_ZDEN : (div0 ? rau_pkg::ST_DIV0 : rau_pkg::ST_OK);
      onum_r <= '0;
      oden_r <= '0;
    end
    if (ctrl.mul2) begin
      p2_r <= mprod;
    end
    if (ctrl.mul3) begin
      p3_r <= mprod;
    end
    if (ctrl.sum) begin
      nm_r <= nmag;
      dm_r <= dmag;
      neg_r <= (num_v[W2-1] != den_v[W2-1]) && (nmag != '0);
      gu_r <= nmag;
      gv_r <= dmag;
      sh_r <= '0;
    end
    // binary gcd: strip common twos, then subtract
    if (ctrl.gcd_step && !stat.gcd_done) begin
      if (gu_r == '0) begin
        gu_r <= gv_r;
        gv_r <= '0;
      end else if (!gu_r[0] && !gv_r[0]) begin
        gu_r <= gu_r >> 1;
        gv_r <= gv_r >> 1;
        sh_r <= sh_r + 1'b1;
      end else if (!gu_r[0]) begin
        gu_r <= gu_r >> 1;
      end else if (!gv_r[0]) begin
        gv_r <= gv_r >> 1;
      end else begin
        gu_r <= (gu_r < gv_r) ? gu_r : gv_r;
        gv_r <= gdiff >> 1;
      end
    end
    if (ctrl.div_init) begin
      gu_r <= gu_r << sh_r;
      q_r <= nm_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (ctrl.div_step && !stat.div_done) begin
      if (rtry >= gu_r) begin
        rem_r <= rtry - gu_r;
        q_r <= {q_r[W2-2:0], 1'b1};
      end else begin
        rem_r <= rtry;
        q_r <= {q_r[W2-2:0], 1'b0};
      end
      cnt_r <= cnt_r + 1'b1;
    end
    if (ctrl.div_save_num) begin
      qn_r <= q_r;
      q_r <= dm_r;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (ctrl.check) begin
      if (q_r > W2'((64'd1 << (WORD_BITS - 1)) - 1) ||
          qn_r > (W2'(64'd1 << (WORD_BITS - 1)) - W2'(!neg_r))) begin
        st_r <= rau_pkg::ST_OVF;
      end else begin
        onum_r <= 32'(signed'(neg_r ? W2'(-qn_r) : qn_r));
        oden_r <= q_r[30:0];
      end
    end
  end

  assign res_num = onum_r;
  assign res_den = oden_r;
  assign res_status = st_r;

endmodule

[bench/tb.sv]
// testbench for the rational arithmetic unit: directed table then random commands
`timescale 1ns / 1ps

module tb;

  localparam int WATCHDOG_LIMIT = 5000;   // cycles with no transfer at all
  localparam int N_RANDOM = 1500;
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_command = '0;
  logic [31:0] in_a_num = '0;
  logic [31:0] in_a_den = 32'd1;
  logic [31:0] in_b_num = '0;
  logic [30:0] in_b_den = 31'd1;
  logic        out_valid;
  logic [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic [1:0]  out_status;

  always #5 clk = ~clk;

  rational_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_res_num(out_res_num),
    .out_res_den(out_res_den), .out_status(out_status)
  );

  // one reduced fraction with its status
  typedef struct packed {
    logic [31:0]      num;
    logic [30:0]      den;
    rau_pkg::status_t st;
  } frac_res_t;

  // one row of the directed table; has_fixed marks a hand-typed answer
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] an;
    logic [31:0] ad;
    logic [31:0] bn;
    logic [30:0] bd;
    bit          has_fixed;
    frac_res_t   fixed;
  } vec_row_t;

  frac_res_t pending_q[$];
  int        n_errors = 0;
  int        n_results = 0;
  int        n_sent = 0;
  int        idle_cycles = 0;
  int        send_gap_pct = 27;
  int        cmd_count[5];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // sign fix, gcd reduction and range check on an exact signed ratio
  function automatic frac_res_t reduce_ratio(logic signed [63:0] n, logic signed [63:0] d);
    frac_res_t   r;
    logic [63:0] nm, dm, g;
    logic        neg;
    nm = n[63] ? -n : n;
    dm = d[63] ? -d : d;
    neg = (n[63] != d[63]) && nm != 0;
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    r = '0;
    if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF)) begin
      r.st = rau_pkg::ST_OVF;
    end else begin
      r.num = neg ? -nm[31:0] : nm[31:0];
      r.den = dm[30:0];
      r.st = rau_pkg::ST_OK;
    end
    return r;
  endfunction

  // expected result of one command; bit 2 alone selects normalise
  function automatic frac_res_t predict_fraction(logic [2:0] cmd, logic [31:0] an_w,
      logic [31:0] ad_w, logic [31:0] bn_w, logic [30:0] bd_w);
    frac_res_t         r;
    logic signed [63:0] an, ad, bn, bd, n, d;
    an = {{32{an_w[31]}}, an_w};
    ad = {{32{ad_w[31]}}, ad_w};
    bn = {{32{bn_w[31]}}, bn_w};
    bd = {33'd0, bd_w};
    r = '0;
    if (cmd[2]) begin
      if (ad == 0) r.st = rau_pkg::ST_ZDEN;
      else r = reduce_ratio(an, ad);
      return r;
    end
    if (ad == 0 || bd == 0) begin
      r.st = rau_pkg::ST_ZDEN;
      return r;
    end
    case (cmd)
      rau_pkg::CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      rau_pkg::CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      rau_pkg::CMD_MUL: begin n = an * bn; d = ad * bd; end
      default: begin
        if (bn == 0) begin
          r.st = rau_pkg::ST_DIV0;
          return r;
        end
        n = an * bd;
        d = ad * bn;
      end
    endcase
    return reduce_ratio(n, d);
  endfunction

  // one transfer: raise start, wait for the accepting edge
  task automatic send_command(logic [2:0] cmd, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [30:0] bd, frac_res_t exp_res);
    while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    start <= 1'b1;
    in_command <= cmd;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    pending_q.push_back(exp_res);
    n_sent++;
    cmd_count[cmd[2] ? 4 : cmd]++;
    start <= 1'b0;
    // the block is busy here anyway; start is low at the next edge
    @(posedge clk);
  endtask

  // random operand: biased towards small magnitudes and the word extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(40);
      2: return -$urandom_range(40);
      3: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return $urandom_range(60000) - 30000;
      default: return $urandom & 32'h0000_FFFF;
    endcase
  endfunction

  // result checking; the receiver cannot stall, so every strobe is taken
  always @(posedge clk) begin
    frac_res_t e;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected: num %h den %h status %0d",
                 $time, out_res_num, out_res_den, out_status);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, out_status);
          n_errors++;
        end
        if (out_res_num !== e.num) begin
          $display("%0t: res_num expected %h actual %h", $time, e.num, out_res_num);
          n_errors++;
        end
        if (out_res_den !== e.den) begin
          $display("%0t: res_den expected %h actual %h", $time, e.den, out_res_den);
          n_errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither an input transfer nor a result
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, nothing transferred for %0d cycles", $time, idle_cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  vec_row_t  vecs[$];

  function automatic vec_row_t mk(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
      logic [31:0] bn, logic [30:0] bd, bit fx, rau_pkg::status_t st,
      logic [31:0] rn, logic [30:0] rd);
    vec_row_t v;
    v.cmd = c; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
    v.has_fixed = fx;
    v.fixed.num = rn; v.fixed.den = rd; v.fixed.st = st;
    return v;
  endfunction

  initial begin
    frac_res_t exp_res;
    logic [2:0] c;
    logic [31:0] an, ad, bn;
    logic [30:0] bd;

    // directed table: fixed answers where obvious, predictor elsewhere
    vecs.push_back(mk(rau_pkg::CMD_ADD,  1, 2, 1, 3, 1, rau_pkg::ST_OK, 5, 6));
    vecs.push_back(mk(rau_pkg::CMD_SUB,  1, 2, 1, 2, 1, rau_pkg::ST_OK, 0, 1));
    vecs.push_back(mk(rau_pkg::CMD_MUL,  2, 3, 3, 4, 1, rau_pkg::ST_OK, 1, 2));
    vecs.push_back(mk(rau_pkg::CMD_DIV,  1, 2, 1, 4, 1, rau_pkg::ST_OK, 2, 1));
    vecs.push_back(mk(rau_pkg::CMD_NORM, 4, -8, 0, 0, 1, rau_pkg::ST_OK, -1, 2));
    vecs.push_back(mk(rau_pkg::CMD_NORM, 0, -5, 0, 0, 1, rau_pkg::ST_OK, 0, 1));
    // zero denominator comes before divide by zero
    vecs.push_back(mk(rau_pkg::CMD_DIV,  1, 0, 0, 1, 1, rau_pkg::ST_ZDEN, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_ADD,  1, 1, 1, 0, 1, rau_pkg::ST_ZDEN, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_NORM, 7, 0, 0, 0, 1, rau_pkg::ST_ZDEN, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_DIV,  3, 5, 0, 7, 1, rau_pkg::ST_DIV0, 0, 0));
    // unused command codes act as normalise
    vecs.push_back(mk(3'd5, 6, -4, 0, 0, 0, rau_pkg::ST_OK, 0, 0));
    vecs.push_back(mk(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 0,
                      rau_pkg::ST_OK, 0, 0));
    // word extremes and overflow
    vecs.push_back(mk(rau_pkg::CMD_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 1,
                      rau_pkg::ST_OVF, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_NORM, 32'h8000_0000, 1, 0, 0, 1,
                      rau_pkg::ST_OK, 32'h8000_0000, 1));
    vecs.push_back(mk(rau_pkg::CMD_ADD, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1,
                      rau_pkg::ST_OVF, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1, 1,
                      rau_pkg::ST_OVF, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_MUL, 1, 32'h7FFF_FFFF, 1, 31'h7FFF_FFFF, 1,
                      rau_pkg::ST_OVF, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      31'h7FFF_FFFF, 0, rau_pkg::ST_OK, 0, 0));
    // negative a_den on arithmetic moves the sign up
    vecs.push_back(mk(rau_pkg::CMD_ADD, 1, -3, 1, 6, 0, rau_pkg::ST_OK, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_DIV, -9, 32'h8000_0000, 32'h8000_0000, 31'h4000_0000, 0,
                      rau_pkg::ST_OK, 0, 0));
    vecs.push_back(mk(rau_pkg::CMD_DIV, 5, 7, -5, 7, 1, rau_pkg::ST_OK, -1, 1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vecs[i]) begin
      exp_res = vecs[i].has_fixed ? vecs[i].fixed
              : predict_fraction(vecs[i].cmd, vecs[i].an, vecs[i].ad, vecs[i].bn, vecs[i].bd);
      send_command(vecs[i].cmd, vecs[i].an, vecs[i].ad, vecs[i].bn, vecs[i].bd, exp_res);
    end

    // hold off until the directed part has fully drained
    while (pending_q.size() != 0) @(posedge clk);

    // random part in three idling phases
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) send_gap_pct = 57;
      if (i == 2 * N_RANDOM / 3) send_gap_pct = 0;
      c = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      an = pick_word();
      ad = ($urandom_range(29) == 0) ? 32'd0 : pick_word();
      if (!c[2] && ad[31] && $urandom_range(3) != 0) ad = -ad;
      bn = ($urandom_range(29) == 0) ? 32'd0 : pick_word();
      bd = ($urandom_range(49) == 0) ? 31'd0 : 31'(pick_word());
      exp_res = predict_fraction(c, an, ad, bn, bd);
      send_command(c, an, ad, bn, bd, exp_res);
    end

    for (int k = 0; k < 20000 && pending_q.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb: %0d commands sent, %0d results checked", n_sent, n_results);
    $display("tb: add %0d sub %0d mul %0d div %0d norm %0d, gaps 27/57/0 percent",
             cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4]);
    if (n_errors == 0 && pending_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, n_errors,
               pending_q.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
